FILE: hw/rtl/mbc1_pkg.sv
package mbc1_pkg;

    // default sizes of the cartridge stores
    localparam int ROM_BANKS_DEF  = 8;
    localparam int RAM_BANKS_DEF  = 4;
    localparam int ROM_BANK_BYTES = 16384;
    localparam int RAM_BANK_BYTES = 8192;

    // widest addresses the stores can ever need
    localparam int ROM_ADDR_MAX_W = 21;
    localparam int RAM_ADDR_MAX_W = 15;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROM_SIZE = 1'b1;

    // ram size codes and the enable key
    localparam logic [1:0] RAM_SIZE_NONE = 2'd0;
    localparam logic [1:0] RAM_SIZE_2K   = 2'd1;
    localparam logic [1:0] RAM_SIZE_32K  = 2'd3;
    localparam logic [3:0] RAM_EN_KEY    = 4'hA;

    localparam logic [7:0] RD_UNMAPPED = 8'hFF;
    localparam logic [7:0] RD_NONE     = 8'h00;

    // request kinds
    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_LOAD  = 2'd2
    } mbc1_req_t;

    // where the read byte comes from
    typedef enum logic [1:0] {
        SEL_ROM   = 2'd0,
        SEL_RAM   = 2'd1,
        SEL_CONST = 2'd2
    } mbc1_sel_t;

    // memory access decoded from one transaction
    typedef struct packed {
        logic                      rom_rd;
        logic                      rom_wr;
        logic [ROM_ADDR_MAX_W-1:0] rom_addr;
        logic                      ram_rd;
        logic                      ram_wr;
        logic [RAM_ADDR_MAX_W-1:0] ram_addr;
        logic [7:0]                wdata;
        mbc1_sel_t                 sel;
        logic [7:0]                fixed;
    } mbc1_mem_req_t;

endpackage

FILE: hw/rtl/mbc1_mem.sv
module mbc1_mem
    import mbc1_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
)(
    input  logic          clk,
    input  logic          re,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/mbc1_bank_regs.sv
module mbc1_bank_regs
    import mbc1_pkg::*;
#(
    parameter int ROM_BANKS = ROM_BANKS_DEF,
    parameter int RAM_BANKS = RAM_BANKS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [1:0]            req_type,
    input  logic [15:0]           bus_addr,
    input  logic [7:0]            wr_data,
    input  logic [16:0]           rom_offset,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output mbc1_mem_req_t         req
);

    localparam int ROM_BYTES = ROM_BANKS * ROM_BANK_BYTES;

    logic [1:0] ram_size_reg;
    logic [2:0] rom_size_reg;
    logic [3:0] ram_en_reg,   ram_en_next;
    logic [4:0] bank_low_reg, bank_low_next;
    logic [1:0] bank_high_reg, bank_high_next;
    logic       bank_mode_reg, bank_mode_next;

    logic [6:0] rom_mod_tbl [128];
    logic [1:0] ram_mod_tbl [4];

    logic [6:0] rom_raw;
    logic [6:0] rom_bank;
    logic [8:0] rom_cnt;
    logic [1:0] ram_bank;
    logic [12:0] ram_off;
    logic       ram_on;

    // bank number modulo the built store sizes
    for (genvar i = 0; i < 128; i++)
    begin : g_rom_mod
        assign rom_mod_tbl[i] = 7'(i % ROM_BANKS);
    end
    for (genvar j = 0; j < 4; j++)
    begin : g_ram_mod
        assign ram_mod_tbl[j] = 2'(j % RAM_BANKS);
    end

    // switchable rom bank
    always_comb
    begin
        rom_raw = bank_mode_reg ? {2'b00, bank_low_reg} : {bank_high_reg, bank_low_reg};
        rom_cnt = 9'd2 << rom_size_reg;
        if (rom_cnt < 9'(ROM_BANKS))
        begin
            rom_bank = rom_raw & 7'(rom_cnt - 9'd1);
        end
        else
        begin
            rom_bank = rom_mod_tbl[rom_raw];
        end
    end

    // ram bank and mirrored offset
    always_comb
    begin
        ram_bank = ram_mod_tbl[(ram_size_reg == RAM_SIZE_32K && bank_mode_reg) ?
                               bank_high_reg : 2'b00];
        ram_off  = (ram_size_reg == RAM_SIZE_2K) ? {2'b00, bus_addr[10:0]} : bus_addr[12:0];
        ram_on   = (ram_size_reg != RAM_SIZE_NONE) && (ram_en_reg == RAM_EN_KEY);
    end

    // decode of one transaction
    always_comb
    begin
        req            = '0;
        req.wdata      = wr_data;
        req.sel        = SEL_CONST;
        req.fixed      = RD_NONE;
        req.rom_addr   = {rom_bank, bus_addr[13:0]};
        req.ram_addr   = {ram_bank, ram_off};
        ram_en_next    = ram_en_reg;
        bank_low_next  = bank_low_reg;
        bank_high_next = bank_high_reg;
        bank_mode_next = bank_mode_reg;
        case (req_type)
            REQ_READ:
            begin
                req.fixed = RD_UNMAPPED;
                case (bus_addr) inside
                    [16'h0000:16'h3FFF]:
                    begin
                        req.rom_rd   = 1'b1;
                        req.sel      = SEL_ROM;
                        req.rom_addr = {7'd0, bus_addr[13:0]};
                    end
                    [16'h4000:16'h7FFF]:
                    begin
                        req.rom_rd = 1'b1;
                        req.sel    = SEL_ROM;
                    end
                    [16'hA000:16'hBFFF]:
                    begin
                        if (ram_on)
                        begin
                            req.ram_rd = 1'b1;
                            req.sel    = SEL_RAM;
                        end
                    end
                    default:
                    begin
                        req.sel = SEL_CONST;
                    end
                endcase
            end
            REQ_WRITE:
            begin
                case (bus_addr) inside
                    [16'h0000:16'h1FFF]: ram_en_next = wr_data[3:0];
                    [16'h2000:16'h3FFF]:
                        bank_low_next = (wr_data[4:0] == 5'd0) ? 5'd1 : wr_data[4:0];
                    [16'h4000:16'h5FFF]: bank_high_next = wr_data[1:0];
                    [16'h6000:16'h7FFF]: bank_mode_next = wr_data[0];
                    [16'hA000:16'hBFFF]: req.ram_wr = ram_on;
                    default:             req.ram_wr = 1'b0;
                endcase
            end
            REQ_LOAD:
            begin
                req.rom_addr = 21'(rom_offset);
                req.rom_wr   = 22'(rom_offset) < 22'(ROM_BYTES);
            end
            default:
            begin
                req.sel = SEL_CONST;
            end
        endcase
        req.rom_rd = req.rom_rd & accept;
        req.rom_wr = req.rom_wr & accept;
        req.ram_rd = req.ram_rd & accept;
        req.ram_wr = req.ram_wr & accept;
    end

    // bank and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_size_reg  <= RAM_SIZE_NONE;
            rom_size_reg  <= 3'd0;
            ram_en_reg    <= 4'd0;
            bank_low_reg  <= 5'd1;
            bank_high_reg <= 2'd0;
            bank_mode_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_RAM_SIZE)
            begin
                ram_size_reg <= cfg_wdata[1:0];
            end
            if (cfg_we && cfg_index == CFG_ROM_SIZE)
            begin
                rom_size_reg <= cfg_wdata[2:0];
            end
            if (accept)
            begin
                ram_en_reg    <= ram_en_next;
                bank_low_reg  <= bank_low_next;
                bank_high_reg <= bank_high_next;
                bank_mode_reg <= bank_mode_next;
            end
        end
    end

endmodule

FILE: hw/rtl/mbc1_bank_controller_unit.sv
// a result passes through the stage-one register and then the output register, which holds while out_stall is high
// throughput: one transaction per cycle while in_stall is low; each takes at most one access on the rom or ram port
// the bank registers update in the accept cycle, so the next transaction sees them
// reset clears the bank registers (low bank to 1), size codes and pipeline valids
// the rom and ram stores are not cleared; their contents are undefined until written
module mbc1_bank_controller_unit
    import mbc1_pkg::*;
#(
    parameter int ROM_BANKS = ROM_BANKS_DEF,
    parameter int RAM_BANKS = RAM_BANKS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            req_type,
    input  logic [15:0]           bus_addr,
    input  logic [7:0]            wr_data,
    input  logic [16:0]           rom_offset,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            rd_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int ROM_DEPTH = ROM_BANKS * ROM_BANK_BYTES;
    localparam int RAM_DEPTH = RAM_BANKS * RAM_BANK_BYTES;
    localparam int ROM_AW    = $clog2(ROM_DEPTH);
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    mbc1_mem_req_t req;
    logic          accept;
    logic          s1_adv;
    logic [7:0]    rom_q, ram_q;

    logic          s1_valid_reg;
    mbc1_sel_t     s1_sel_reg;
    logic [7:0]    s1_fixed_reg;
    logic          out_valid_reg;
    logic [7:0]    rd_data_reg, rd_data_next;

    // handshake: stage one moves on when the output register is free or drained
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign accept   = in_valid && !in_stall;

    mbc1_bank_regs #(
        .ROM_BANKS (ROM_BANKS),
        .RAM_BANKS (RAM_BANKS)
    ) u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .req_type   (req_type),
        .bus_addr   (bus_addr),
        .wr_data    (wr_data),
        .rom_offset (rom_offset),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .req        (req)
    );

    mbc1_mem #(
        .DEPTH (ROM_DEPTH),
        .AW    (ROM_AW)
    ) u_rom (
        .clk   (clk),
        .re    (req.rom_rd),
        .we    (req.rom_wr),
        .addr  (req.rom_addr[ROM_AW-1:0]),
        .wdata (req.wdata),
        .rdata (rom_q)
    );

    mbc1_mem #(
        .DEPTH (RAM_DEPTH),
        .AW    (RAM_AW)
    ) u_ram (
        .clk   (clk),
        .re    (req.ram_rd),
        .we    (req.ram_wr),
        .addr  (req.ram_addr[RAM_AW-1:0]),
        .wdata (req.wdata),
        .rdata (ram_q)
    );

    // pick the result byte once the memory read returns
    always_comb
    begin
        case (s1_sel_reg)
            SEL_ROM: rd_data_next = rom_q;
            SEL_RAM: rd_data_next = ram_q;
            default: rd_data_next = s1_fixed_reg;
        endcase
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sel_reg   <= req.sel;
            s1_fixed_reg <= req.fixed;
        end
        if (s1_adv)
        begin
            rd_data_reg <= rd_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign rd_data   = rd_data_reg;

    // an accepted transaction always reaches stage one
    a_accept_fills_s1 : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted transaction did not reach stage one");

    // a stage-one result moving on shows up at the output
    a_adv_fills_out : assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("stage-one result lost on the way to the output");

    // a full pipeline with a stalled output refuses new transactions
    a_full_stalls : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && out_stall) |-> in_stall)
        else $error("transaction accepted while the pipeline is full");

    // external ram is only touched in its own address window
    a_ram_window : assert property (@(posedge clk) disable iff (!rst_n)
        (req.ram_rd || req.ram_wr) |-> (bus_addr[15:13] == 3'b101))
        else $error("ram access outside its address window");

endmodule

FILE: dv/mbc1_bank_controller_unit_tb.sv
module mbc1_bank_controller_unit_tb;
    import mbc1_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROM_BYTES = ROM_BANKS_DEF * ROM_BANK_BYTES;
    localparam int RAM_BYTES = RAM_BANKS_DEF * RAM_BANK_BYTES;
    localparam int PHASE_TXNS = 150;
    localparam int DRAIN_CYCLES = 4;
    localparam int IDLE_PCT = 37;
    localparam logic [1:0] REQ_UNDEF = 2'd3;

    // one line of the directed stimulus table
    typedef struct {
        bit                    is_cfg;
        logic [1:0]            req;
        logic [15:0]           addr;
        logic [7:0]            data;
        logic [16:0]           off;
        bit                    typed;
        logic [7:0]            want;
        logic [CFG_IDX_W-1:0]  cfg_idx;
        logic [CFG_DATA_W-1:0] cfg_val;
    } step_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [1:0]            req_type;
    logic [15:0]           bus_addr;
    logic [7:0]            wr_data;
    logic [16:0]           rom_offset;
    logic                  out_valid;
    logic                  out_stall;
    logic [7:0]            rd_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // cartridge state as the predictor sees it
    logic [1:0]  ram_code;
    logic [2:0]  rom_code;
    logic [3:0]  ram_key;
    logic [4:0]  bank_lo;
    logic [1:0]  bank_hi;
    logic        bank_mode;
    logic [7:0]  rom_img [ROM_BYTES];
    logic [7:0]  ram_img [RAM_BYTES];
    bit          rom_seen [ROM_BYTES];
    bit          ram_seen [RAM_BYTES];

    logic [7:0]  rd_data_due [$];
    logic [13:0] hot_offsets [16];
    step_row_t   dir_rows [$];
    bit          calm;
    int          txn_count;
    int          checked_count;
    int          cfg_count;
    int          bad_count;

    mbc1_bank_controller_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .bus_addr   (bus_addr),
        .wr_data    (wr_data),
        .rom_offset (rom_offset),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .rd_data    (rd_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("mbc1_bank_controller_unit_tb failed");
        $finish;
    end

    // rom bank count from the size code, capped at the built size
    function automatic int unsigned rom_bank_count();
        int unsigned n;
        n = 2 << rom_code;
        return (n > ROM_BANKS_DEF) ? ROM_BANKS_DEF : n;
    endfunction

    // linear rom byte behind a bus address below 0x8000
    function automatic int unsigned rom_index(logic [15:0] addr);
        int unsigned bank;
        if (!addr[14])
            return 32'(addr[13:0]);
        bank = 32'(bank_mode ? {2'b00, bank_lo} : {bank_hi, bank_lo});
        return (bank % rom_bank_count()) * ROM_BANK_BYTES + 32'(addr[13:0]);
    endfunction

    // linear ram byte behind a bus address in the external ram window
    function automatic int unsigned ram_index(logic [15:0] addr);
        logic [12:0] ofs;
        int unsigned bank;
        ofs = addr[12:0];
        if (ram_code == RAM_SIZE_2K)
            ofs[12:11] = 2'b00;
        bank = (ram_code == RAM_SIZE_32K && bank_mode) ? bank_hi : 0;
        return (bank % RAM_BANKS_DEF) * RAM_BANK_BYTES + ofs;
    endfunction

    function automatic bit ram_live();
        return ram_code != RAM_SIZE_NONE && ram_key == RAM_EN_KEY;
    endfunction

    // apply one transaction to the cartridge state and return the byte it reads
    function automatic logic [7:0] cart_access(logic [1:0] req, logic [15:0] addr,
                                               logic [7:0] data, logic [16:0] off);
        logic [7:0] got;
        got = RD_NONE;
        case (req)
            REQ_READ:
            begin
                if (!addr[15])
                    got = rom_img[rom_index(addr)];
                else if (addr[15:13] == 3'b101 && ram_live())
                    got = ram_img[ram_index(addr)];
                else
                    got = RD_UNMAPPED;
            end
            REQ_WRITE:
            begin
                case (addr[15:13])
                    3'b000: ram_key = data[3:0];
                    3'b001: bank_lo = (data[4:0] == 5'd0) ? 5'd1 : data[4:0];
                    3'b010: bank_hi = data[1:0];
                    3'b011: bank_mode = data[0];
                    3'b101:
                    begin
                        if (ram_live())
                        begin
                            ram_img[ram_index(addr)] = data;
                            ram_seen[ram_index(addr)] = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            REQ_LOAD:
            begin
                if (off < ROM_BYTES)
                begin
                    rom_img[off] = data;
                    rom_seen[off] = 1'b1;
                end
            end
            default: ;
        endcase
        return got;
    endfunction

    function automatic bit take_gap();
        return !calm && $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    // offset inside a bank, mostly from a small set so reads find loaded bytes
    function automatic logic [13:0] pick_spot();
        return ($urandom_range(0, 3) != 0) ? hot_offsets[$urandom_range(0, 15)]
                                           : 14'($urandom);
    endfunction

    function automatic step_row_t bus_row(logic [1:0] req, logic [15:0] addr,
                                          logic [7:0] data, logic [16:0] off,
                                          bit typed, logic [7:0] want);
        return '{1'b0, req, addr, data, off, typed, want, '0, '0};
    endfunction

    function automatic step_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] val);
        return '{1'b1, REQ_UNDEF, 16'h0, 8'h0, 17'h0, 1'b0, 8'h0, idx, val};
    endfunction

    // offer one transaction, wait for it to be taken, then record its expected byte
    task automatic send_txn(input logic [1:0] r, input logic [15:0] a, input logic [7:0] d,
                            input logic [16:0] o, input bit typed, input logic [7:0] want);
        logic [7:0] model_byte;
        @(negedge clk);
        while (take_gap())
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        req_type = r;
        bus_addr = a;
        wr_data = d;
        rom_offset = o;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        model_byte = cart_access(r, a, d, o);
        rd_data_due.push_back(typed ? want : model_byte);
        txn_count++;
    endtask

    // stop offering and wait for every outstanding read byte
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (rd_data_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        drain();
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_RAM_SIZE)
            ram_code = val[1:0];
        else
            rom_code = val[2:0];
        cfg_count++;
    endtask

    // random transaction, mostly well formed cartridge traffic
    task automatic pick_txn(output logic [1:0] r, output logic [15:0] a,
                            output logic [7:0] d, output logic [16:0] o);
        int unsigned roll;
        logic [1:0] which;
        logic [13:0] spot;
        roll = $urandom_range(0, 99);
        a = 16'($urandom);
        d = 8'($urandom);
        o = 17'($urandom);
        r = REQ_READ;
        if (roll < 30)
        begin
            // rom read, turned into a load when the byte was never written
            a = {1'b0, 1'($urandom), pick_spot()};
            if (!rom_seen[rom_index(a)])
            begin
                r = REQ_LOAD;
                o = 17'(rom_index(a));
            end
        end
        else if (roll < 40)
        begin
            r = REQ_LOAD;
            o = {3'($urandom), pick_spot()};
        end
        else if (roll < 75)
        begin
            // external ram access; an unwritten read becomes a store
            spot = pick_spot();
            a = {3'b101, spot[12:0]};
            if (roll >= 60 || (ram_live() && !ram_seen[ram_index(a)]))
                r = REQ_WRITE;
        end
        else if (roll < 90)
        begin
            which = 2'($urandom);
            a = {1'b0, which, 13'($urandom)};
            r = REQ_WRITE;
            if (which == 2'd0 && $urandom_range(0, 9) < 7)
                d = {4'($urandom), RAM_EN_KEY};
            else if (which == 2'd1 && $urandom_range(0, 9) == 0)
                d = {3'($urandom), 5'd0};
        end
        else if (roll < 95)
        begin
            a = $urandom_range(0, 1) ? {3'b100, 13'($urandom)} : {2'b11, 14'($urandom)};
            r = $urandom_range(0, 1) ? REQ_READ : REQ_WRITE;
        end
        else
            r = REQ_UNDEF;
    endtask

    // receiver stalls
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall = !calm && $urandom_range(0, 99) < IDLE_PCT;
        end
    end

    // compare each read byte with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (rd_data_due.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none actual rd_data %02h",
                         $time, rd_data);
                bad_count++;
            end
            else
            begin
                if (rd_data !== rd_data_due[0])
                begin
                    $display("%0t: rd_data mismatch, expected %02h actual %02h",
                             $time, rd_data_due[0], rd_data);
                    bad_count++;
                end
                void'(rd_data_due.pop_front());
                checked_count++;
            end
        end
    end

    // stimulus
    initial
    begin
        logic [1:0]  r;
        logic [15:0] a;
        logic [7:0]  d;
        logic [16:0] o;
        logic [2:0]  phase_ram [8];
        logic [2:0]  phase_rom [8];

        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = REQ_READ;
        bus_addr = 16'h0;
        wr_data = 8'h0;
        rom_offset = 17'h0;
        cfg_we = 1'b0;
        cfg_index = CFG_RAM_SIZE;
        cfg_wdata = '0;
        calm = 1'b0;
        txn_count = 0;
        checked_count = 0;
        cfg_count = 0;
        bad_count = 0;

        // state after reset
        ram_code = RAM_SIZE_NONE;
        rom_code = 3'd0;
        ram_key = 4'h0;
        bank_lo = 5'd1;
        bank_hi = 2'd0;
        bank_mode = 1'b0;

        hot_offsets[0] = 14'h0000;
        hot_offsets[1] = 14'h3FFF;
        hot_offsets[2] = 14'h1FFF;
        hot_offsets[3] = 14'h07FF;
        for (int i = 4; i < 16; i++)
            hot_offsets[i] = 14'($urandom);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset values, extremes and the special cases
        dir_rows.push_back(bus_row(REQ_LOAD, 16'h0000, 8'h11, 17'h00000, 1'b1, RD_NONE));
        dir_rows.push_back(bus_row(REQ_LOAD, 16'hFFFF, 8'h22, 17'h04000, 1'b1, RD_NONE));
        dir_rows.push_back(bus_row(REQ_LOAD, 16'h0000, 8'hEE, 17'h1FFFF, 1'b1, RD_NONE));
        dir_rows.push_back(bus_row(REQ_READ, 16'h0000, 8'hFF, 17'h1FFFF, 1'b1, 8'h11));
        dir_rows.push_back(bus_row(REQ_READ, 16'h4000, 8'h00, 17'h00000, 1'b1, 8'h22));
        dir_rows.push_back(bus_row(REQ_READ, 16'hA000, 8'h00, 17'h00000, 1'b1, RD_UNMAPPED));
        dir_rows.push_back(bus_row(REQ_READ, 16'h9FFF, 8'h00, 17'h00000, 1'b1, RD_UNMAPPED));
        dir_rows.push_back(bus_row(REQ_READ, 16'hFFFF, 8'h00, 17'h00000, 1'b1, RD_UNMAPPED));
        dir_rows.push_back(bus_row(REQ_UNDEF, 16'hFFFF, 8'hFF, 17'h1FFFF, 1'b1, RD_NONE));
        // size code seven exceeds the built bank count and is capped at it
        dir_rows.push_back(reg_row(CFG_ROM_SIZE, 3'd7));
        dir_rows.push_back(reg_row(CFG_RAM_SIZE, 3'(RAM_SIZE_32K)));
        // low bank written as zero reads as bank one
        dir_rows.push_back(bus_row(REQ_WRITE, 16'h2000, 8'h00, 17'h00000, 1'b1, RD_NONE));
        dir_rows.push_back(bus_row(REQ_READ, 16'h4000, 8'h00, 17'h00000, 1'b0, 8'h00));
        dir_rows.push_back(bus_row(REQ_WRITE, 16'h3FFF, 8'hFF, 17'h00000, 1'b1, RD_NONE));
        dir_rows.push_back(bus_row(REQ_READ, 16'h7FFF, 8'h00, 17'h00000, 1'b0, 8'h00));
        dir_rows.push_back(bus_row(REQ_WRITE, 16'h1FFF, 8'hFA, 17'h00000, 1'b1, RD_NONE));
        dir_rows.push_back(bus_row(REQ_WRITE, 16'hA000, 8'h5C, 17'h00000, 1'b1, RD_NONE));
        dir_rows.push_back(bus_row(REQ_READ, 16'hA000, 8'h00, 17'h00000, 1'b0, 8'h00));
        // mode one selects the ram bank from the high bank
        dir_rows.push_back(bus_row(REQ_WRITE, 16'h6000, 8'h01, 17'h00000, 1'b1, RD_NONE));
        dir_rows.push_back(bus_row(REQ_WRITE, 16'h5FFF, 8'hFF, 17'h00000, 1'b1, RD_NONE));
        dir_rows.push_back(bus_row(REQ_WRITE, 16'hBFFF, 8'hA5, 17'h00000, 1'b1, RD_NONE));
        dir_rows.push_back(bus_row(REQ_READ, 16'hBFFF, 8'h00, 17'h00000, 1'b0, 8'h00));
        dir_rows.push_back(bus_row(REQ_READ, 16'h7FFF, 8'h00, 17'h00000, 1'b0, 8'h00));
        // ram disabled: reads give all ones, stores are dropped
        dir_rows.push_back(bus_row(REQ_WRITE, 16'h0000, 8'h00, 17'h00000, 1'b1, RD_NONE));
        dir_rows.push_back(bus_row(REQ_WRITE, 16'hBFFF, 8'h00, 17'h00000, 1'b1, RD_NONE));
        dir_rows.push_back(bus_row(REQ_READ, 16'hBFFF, 8'h00, 17'h00000, 1'b1, RD_UNMAPPED));
        dir_rows.push_back(bus_row(REQ_WRITE, 16'hC000, 8'hFF, 17'h00000, 1'b1, RD_NONE));

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
                write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
            else
                send_txn(dir_rows[i].req, dir_rows[i].addr, dir_rows[i].data,
                         dir_rows[i].off, dir_rows[i].typed, dir_rows[i].want);
        end

        // random phases over several size settings, extremes included
        phase_ram = '{3'd1, 3'd2, 3'd3, 3'd0, 3'd3, 3'd1, 3'd2, 3'd3};
        phase_rom = '{3'd0, 3'd3, 3'd7, 3'd6, 3'd1, 3'd5, 3'd2, 3'd4};
        for (int p = 0; p < 8; p++)
        begin
            write_reg(CFG_RAM_SIZE, phase_ram[p]);
            write_reg(CFG_ROM_SIZE, phase_rom[p]);
            // one phase runs back to back with no gaps and no stalls
            calm = (p == 4);
            repeat (PHASE_TXNS)
            begin
                pick_txn(r, a, d, o);
                send_txn(r, a, d, o, 1'b0, 8'h00);
            end
        end
        calm = 1'b0;

        drain();
        $display("%0d transactions accepted, %0d read bytes compared, %0d register writes",
                 txn_count, checked_count, cfg_count);
        $display("size settings covered ram codes 0..3 and rom codes 0..7");
        if (bad_count == 0)
            $display("mbc1_bank_controller_unit_tb passed");
        else
            $display("mbc1_bank_controller_unit_tb failed");
        $finish;
    end

endmodule
